// ===== design/nfare_pkg.sv =====
// ----------------------------------------------------------------------------
// nfare_pkg
// Shared types and constants for the Thompson NFA match engine: table entry
// layout, label codes, operation codes and stream packing offsets.
// ----------------------------------------------------------------------------
package nfare_pkg;

    // table geometry
    localparam int NUM_STATES = 64;
    localparam int IDX_W      = $clog2(NUM_STATES);
    localparam int LINK_W     = 7;
    localparam int LABEL_W    = 9;
    localparam int CHAR_W     = 8;
    localparam int CNT_W      = 7;
    localparam int SP_W       = IDX_W + 1;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [LINK_W-1:0]  link_t;
    typedef logic [LABEL_W-1:0] label_t;
    typedef logic [CHAR_W-1:0]  char_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [SP_W-1:0]    sp_t;

    // label codes above the byte range
    localparam label_t LBL_MATCH  = label_t'(256);
    localparam label_t LBL_BRANCH = label_t'(257);

    // operation codes
    typedef logic [1:0] op_t;
    localparam op_t OP_WRITE = 2'd0;
    localparam op_t OP_BEGIN = 2'd1;
    localparam op_t OP_CHAR  = 2'd2;

    // one table entry
    typedef struct packed {
        label_t label;
        link_t  nxt;
        link_t  br;
    } entry_t;

    // one input item
    typedef struct packed {
        op_t    op;
        idx_t   idx;
        label_t label;
        link_t  nxt;
        link_t  br;
        char_t  ch;
    } req_t;

    // one result item
    typedef struct packed {
        logic matched;
        cnt_t count;
    } res_t;

    // stream packing, lowest field first
    localparam int TD_IDX_LO = 0;
    localparam int TD_LBL_LO = TD_IDX_LO + IDX_W;
    localparam int TD_NXT_LO = TD_LBL_LO + LABEL_W;
    localparam int TD_BR_LO  = TD_NXT_LO + LINK_W;
    localparam int TD_CH_LO  = TD_BR_LO + LINK_W;
    localparam int S_TDATA_W = ((TD_CH_LO + CHAR_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((1 + CNT_W + 7) / 8) * 8;

    // a link names an entry only when it is below the table depth
    function automatic logic link_ok(link_t l);
        return l < LINK_W'(NUM_STATES);
    endfunction

endpackage

// ===== design/nfare_engine.sv =====
// ----------------------------------------------------------------------------
// nfare_engine
// Table memory, work stack memory and the sequencer that scans the active
// set and walks the epsilon closure one entry at a time.
// ----------------------------------------------------------------------------
module nfare_engine (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  nfare_pkg::req_t       in_req,
    input  nfare_pkg::idx_t       start_state,
    output logic                  res_valid,
    output nfare_pkg::res_t       res,
    input  logic                  res_take
);
    import nfare_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_WR   = 8'b0000_0010,
        ST_SCAN = 8'b0000_0100,
        ST_POP  = 8'b0000_1000,
        ST_ADDR = 8'b0001_0000,
        ST_EVAL = 8'b0010_0000,
        ST_FIN  = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } state_t;

    localparam logic [NUM_STATES-1:0] SET_ONE = {{(NUM_STATES-1){1'b0}}, 1'b1};

    state_t               state_reg, state_next;
    req_t                 req_reg, req_next;
    logic [NUM_STATES-1:0] active_reg, active_next;
    logic [NUM_STATES-1:0] pending_reg, pending_next;
    logic [NUM_STATES-1:0] visited_reg, visited_next;
    cnt_t                 cnt_reg, cnt_next;
    cnt_t                 mcnt_reg, mcnt_next;
    cnt_t                 pcnt_reg, pcnt_next;
    cnt_t                 pmcnt_reg, pmcnt_next;
    sp_t                  i_reg, i_next;
    logic                 rd_vld_reg, rd_vld_next;
    idx_t                 rd_idx_reg, rd_idx_next;
    idx_t                 cur_reg, cur_next;
    sp_t                  sp_reg, sp_next;

    // table memory
    entry_t tab_mem [NUM_STATES];
    entry_t tab_q;
    entry_t tab_wd;
    idx_t   tab_wa, tab_ra;
    logic   tab_we;

    // work stack memory
    idx_t   stk_mem [NUM_STATES];
    idx_t   stk_q, stk_wd, stk_ra;
    logic   stk_we;

    // decode of the entry that was read last cycle
    entry_t new_ent;
    idx_t   nxt_idx, br_idx;
    logic   a_ok, b_ok, scan_hit;
    sp_t    sp_dec;

    always_ff @(posedge aclk) begin
        if (tab_we) begin
            tab_mem[tab_wa] <= tab_wd;
        end
        tab_q <= tab_mem[tab_ra];
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[sp_reg[IDX_W-1:0]] <= stk_wd;
        end
        stk_q <= stk_mem[stk_ra];
    end

    assign new_ent  = '{label: req_reg.label, nxt: req_reg.nxt, br: req_reg.br};
    assign nxt_idx  = tab_q.nxt[IDX_W-1:0];
    assign br_idx   = tab_q.br[IDX_W-1:0];
    assign a_ok     = link_ok(tab_q.nxt) && !visited_reg[nxt_idx];
    assign b_ok     = link_ok(tab_q.br) && !visited_reg[br_idx]
                      && !(a_ok && (tab_q.br == tab_q.nxt));
    assign scan_hit = rd_vld_reg && active_reg[rd_idx_reg]
                      && (tab_q.label == {1'b0, req_reg.ch})
                      && link_ok(tab_q.nxt) && !visited_reg[nxt_idx];
    assign sp_dec   = sp_reg - SP_W'(1);

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res.matched = (mcnt_reg != '0);
    assign res.count   = cnt_reg;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        active_next  = active_reg;
        pending_next = pending_reg;
        visited_next = visited_reg;
        cnt_next     = cnt_reg;
        mcnt_next    = mcnt_reg;
        pcnt_next    = pcnt_reg;
        pmcnt_next   = pmcnt_reg;
        i_next       = i_reg;
        rd_vld_next  = 1'b0;
        rd_idx_next  = rd_idx_reg;
        cur_next     = cur_reg;
        sp_next      = sp_reg;
        tab_we       = 1'b0;
        tab_wa       = req_reg.idx;
        tab_wd       = new_ent;
        tab_ra       = cur_reg;
        stk_we       = 1'b0;
        stk_wd       = br_idx;
        stk_ra       = sp_dec[IDX_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    req_next = in_req;
                    case (in_req.op)
                        OP_WRITE: begin
                            tab_ra     = in_req.idx;
                            state_next = ST_WR;
                        end
                        OP_BEGIN: begin
                            visited_next = SET_ONE << start_state;
                            pending_next = '0;
                            pcnt_next    = '0;
                            pmcnt_next   = '0;
                            sp_next      = '0;
                            cur_next     = start_state;
                            tab_ra       = start_state;
                            state_next   = ST_EVAL;
                        end
                        OP_CHAR: begin
                            visited_next = '0;
                            pending_next = '0;
                            pcnt_next    = '0;
                            pmcnt_next   = '0;
                            sp_next      = '0;
                            i_next       = '0;
                            state_next   = ST_SCAN;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            // read old entry last cycle, now write and fix the live counts
            ST_WR: begin
                tab_we = 1'b1;
                if (active_reg[req_reg.idx]) begin
                    cnt_next = cnt_reg
                               - CNT_W'(tab_q.label != LBL_BRANCH)
                               + CNT_W'(req_reg.label != LBL_BRANCH);
                    mcnt_next = mcnt_reg
                                - CNT_W'(tab_q.label == LBL_MATCH)
                                + CNT_W'(req_reg.label == LBL_MATCH);
                end
                state_next = ST_DONE;
            end

            // one table read a cycle, seeds go onto the stack
            ST_SCAN: begin
                if (i_reg != SP_W'(NUM_STATES)) begin
                    tab_ra      = i_reg[IDX_W-1:0];
                    rd_idx_next = i_reg[IDX_W-1:0];
                    rd_vld_next = 1'b1;
                    i_next      = i_reg + SP_W'(1);
                end
                if (scan_hit) begin
                    stk_we                = 1'b1;
                    stk_wd                = nxt_idx;
                    sp_next               = sp_reg + SP_W'(1);
                    visited_next[nxt_idx] = 1'b1;
                end
                if ((i_reg == SP_W'(NUM_STATES)) && !rd_vld_reg) begin
                    state_next = ST_POP;
                end
            end

            ST_POP: begin
                if (sp_reg == '0) begin
                    state_next = ST_FIN;
                end else begin
                    sp_next    = sp_dec;
                    state_next = ST_ADDR;
                end
            end

            ST_ADDR: begin
                cur_next   = stk_q;
                tab_ra     = stk_q;
                state_next = ST_EVAL;
            end

            // expand a branch entry or record a plain one
            ST_EVAL: begin
                if (tab_q.label == LBL_BRANCH) begin
                    if (a_ok) begin
                        visited_next[nxt_idx] = 1'b1;
                        cur_next              = nxt_idx;
                        tab_ra                = nxt_idx;
                        if (b_ok) begin
                            visited_next[br_idx] = 1'b1;
                            stk_we               = 1'b1;
                            sp_next              = sp_reg + SP_W'(1);
                        end
                    end else if (b_ok) begin
                        visited_next[br_idx] = 1'b1;
                        cur_next             = br_idx;
                        tab_ra               = br_idx;
                    end else if (sp_reg == '0) begin
                        state_next = ST_FIN;
                    end else begin
                        sp_next    = sp_dec;
                        state_next = ST_ADDR;
                    end
                end else begin
                    pending_next[cur_reg] = 1'b1;
                    pcnt_next             = pcnt_reg + CNT_W'(1);
                    if (tab_q.label == LBL_MATCH) begin
                        pmcnt_next = pmcnt_reg + CNT_W'(1);
                    end
                    if (sp_reg == '0) begin
                        state_next = ST_FIN;
                    end else begin
                        sp_next    = sp_dec;
                        state_next = ST_ADDR;
                    end
                end
            end

            ST_FIN: begin
                active_next = pending_reg;
                cnt_next    = pcnt_reg;
                mcnt_next   = pmcnt_reg;
                state_next  = ST_DONE;
            end

            ST_DONE: begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            active_reg  <= '0;
            pending_reg <= '0;
            visited_reg <= '0;
            cnt_reg     <= '0;
            mcnt_reg    <= '0;
            pcnt_reg    <= '0;
            pmcnt_reg   <= '0;
            i_reg       <= '0;
            rd_vld_reg  <= 1'b0;
            sp_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            pending_reg <= pending_next;
            visited_reg <= visited_next;
            cnt_reg     <= cnt_next;
            mcnt_reg    <= mcnt_next;
            pcnt_reg    <= pcnt_next;
            pmcnt_reg   <= pmcnt_next;
            i_reg       <= i_next;
            rd_vld_reg  <= rd_vld_next;
            sp_reg      <= sp_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        rd_idx_reg <= rd_idx_next;
        cur_reg    <= cur_next;
    end

    // each entry enters the stack at most once
    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SP_W'(NUM_STATES))
        else $error("work stack deeper than the table");

    // only visited entries can become pending
    a_pend_visited: assert property (@(posedge aclk) disable iff (!aresetn)
        (pending_reg & ~visited_reg) == '0)
        else $error("pending entry not marked visited");

    // running count tracks the pending set
    a_pcnt: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(pending_reg) == int'(pcnt_reg))
        else $error("pending count out of step");

    // commit copies the pending set and the pending count
    a_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FIN |=> (active_reg == $past(pending_reg))
                                && (cnt_reg == $past(pcnt_reg)))
        else $error("active set not committed");

endmodule

// ===== design/nfa_regex_match_engine_core.sv =====
// ----------------------------------------------------------------------------
// nfa_regex_match_engine_core
// Thompson NFA simulation over a 64-entry state table, with a streaming item
// input, a streaming result output and one start-entry register.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  s_tuser op, s_tdata entry / char
//  m_*       out        m_tvalid / m_tready  m_tdata matched, active count
//  cfg_*     in         cfg_we               cfg_wdata start entry index
//
//  one item at a time; s_tready is high only while the sequencer is idle
//  write: read old entry, write back, result
//  begin: evaluate the start entry and each entry reached in the closure
//  char: scan of the whole table, then each closure entry; the single
//  table read port sets the pace
//  result sits in an output register; a stalled m_tready holds the engine
//  after it finishes, not while it works. reset clears all sets and counts
// ----------------------------------------------------------------------------
module nfa_regex_match_engine_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [5:0] entry_index, [14:6] entry_label, [21:15] entry_next,
    // [28:22] entry_branch, [36:29] text_char, rest zero
    input  logic [nfare_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] operation
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] matched, [7:1] active_count
    output logic [nfare_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                            cfg_we,
    input  logic [nfare_pkg::IDX_W-1:0]     cfg_wdata
);
    import nfare_pkg::*;

    idx_t start_reg;
    logic m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    req_t in_req;
    res_t res;
    logic res_valid, res_take;

    // unpack the input item
    assign in_req.op    = s_tuser;
    assign in_req.idx   = s_tdata[TD_IDX_LO +: IDX_W];
    assign in_req.label = s_tdata[TD_LBL_LO +: LABEL_W];
    assign in_req.nxt   = s_tdata[TD_NXT_LO +: LINK_W];
    assign in_req.br    = s_tdata[TD_BR_LO +: LINK_W];
    assign in_req.ch    = s_tdata[TD_CH_LO +: CHAR_W];

    nfare_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_req      (in_req),
        .start_state (start_reg),
        .res_valid   (res_valid),
        .res         (res),
        .res_take    (res_take)
    );

    // start entry register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
        end else if (cfg_we) begin
            start_reg <= cfg_wdata;
        end
    end

    // output register
    assign res_take = res_valid && (!m_tvalid_reg || m_tready);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (res_take) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_TDATA_W'({res.count, res.matched});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
